@@ src/c2s_pkg.sv @@
// Package for the cartesian-to-spherical converter: turn constants, the CORDIC
// arctangent table and the elaboration-time gain computation.
// No dependencies.
`timescale 1ns / 1ps

package c2s_pkg;

  localparam int FRAC_GUARD = 8;   // extra fraction bits carried inside the CORDIC
  localparam int GAIN_FRAC  = 20;  // fraction bits of the CORDIC gain constant
  localparam int TURN_W     = 32;  // internal angle width, one full turn

  localparam logic [TURN_W-1:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [TURN_W-1:0] THREE_QUARTER = 32'hC000_0000;

  // atan(2^-i) as a fraction of a full turn, rounded
  localparam logic [TURN_W-1:0] ARC_TABLE [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // CORDIC gain K in Q20: integer square root of prod(1 + 4^-i) formed in Q40.
  // Elaboration only.
  function automatic logic [63:0] gain_q20(input int stages);
    logic [63:0] prod;
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bitv;
    int          n;
    prod = 64'd1 << 40;
    n    = (stages > 32) ? 32 : stages;
    for (int i = 0; i < 32; i++) begin
      if (i < n) begin
        prod = prod + (prod >> (2 * i));
      end
    end
    rem  = prod;
    res  = '0;
    bitv = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (bitv > rem) begin
        bitv = bitv >> 2;
      end
    end
    for (int j = 0; j < 32; j++) begin
      if (bitv != 64'd0) begin
        if (rem >= res + bitv) begin
          rem = rem - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
    end
    return res;
  endfunction

endpackage

@@ src/c2s_cordic.sv @@
// Unrolled CORDIC vectoring pipeline, one register stage per iteration.
// Depends on c2s_pkg (arctangent table, turn width).
`timescale 1ns / 1ps

module c2s_cordic #(
  parameter int W      = 27,
  parameter int STAGES = 16,
  parameter int SIDE_W = 17
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic signed [W-1:0]            a_i,
  input  logic signed [W-1:0]            b_i,
  input  logic [c2s_pkg::TURN_W-1:0]     ang_i,
  input  logic [SIDE_W-1:0]              side_i,
  output logic                           valid_o,
  output logic signed [W-1:0]            a_o,
  output logic [c2s_pkg::TURN_W-1:0]     ang_o,
  output logic [SIDE_W-1:0]              side_o
);

  logic                          valid_q [STAGES];
  logic signed [W-1:0]           a_q     [STAGES];
  logic signed [W-1:0]           b_q     [STAGES];
  logic [c2s_pkg::TURN_W-1:0]    ang_q   [STAGES];
  logic [SIDE_W-1:0]             side_q  [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic                        v_in;
    logic signed [W-1:0]         a_in, b_in, a_d, b_d;
    logic [c2s_pkg::TURN_W-1:0]  ang_in, ang_d;
    logic [SIDE_W-1:0]           side_in;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign a_in    = a_i;
      assign b_in    = b_i;
      assign ang_in  = ang_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = valid_q[k-1];
      assign a_in    = a_q[k-1];
      assign b_in    = b_q[k-1];
      assign ang_in  = ang_q[k-1];
      assign side_in = side_q[k-1];
    end

    // drive b toward zero; both updates use the old values
    always_comb begin
      if (!b_in[W-1]) begin
        a_d   = a_in + (b_in >>> k);
        b_d   = b_in - (a_in >>> k);
        ang_d = ang_in + c2s_pkg::ARC_TABLE[k];
      end else begin
        a_d   = a_in - (b_in >>> k);
        b_d   = b_in + (a_in >>> k);
        ang_d = ang_in - c2s_pkg::ARC_TABLE[k];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_q[k]    <= a_d;
        b_q[k]    <= b_d;
        ang_q[k]  <= ang_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[STAGES-1];
  assign a_o     = a_q[STAGES-1];
  assign ang_o   = ang_q[STAGES-1];
  assign side_o  = side_q[STAGES-1];

endmodule

@@ src/c2s_gain.sv @@
// Gain removal: floor(m * 2^20 / K) by reciprocal multiply and one correction,
// three register stages. Depends on c2s_pkg (gain function, gain fraction).
`timescale 1ns / 1ps

module c2s_gain #(
  parameter int W      = 27,
  parameter int STAGES = 16,
  parameter int SIDE_W = 49
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [W-1:0]  mag_i,
  input  logic [SIDE_W-1:0]    side_i,
  output logic                 valid_o,
  output logic [W-2:0]         quot_o,
  output logic [SIDE_W-1:0]    side_o
);

  localparam int          M_W    = W - 1;
  localparam logic [63:0] GAIN   = c2s_pkg::gain_q20(STAGES);
  localparam int          K_W    = $clog2(GAIN + 64'd1);
  localparam logic [63:0] RECIP  = (64'd1 << (c2s_pkg::GAIN_FRAC + M_W)) / GAIN;
  localparam int          R_W    = $clog2(RECIP + 64'd1);
  localparam int          P1_W   = M_W + R_W;
  localparam int          P2_W   = M_W + K_W;
  localparam int          D_W    = M_W + c2s_pkg::GAIN_FRAC + 2;
  localparam logic [K_W-1:0] GAIN_K  = GAIN[K_W-1:0];
  localparam logic [R_W-1:0] RECIP_K = RECIP[R_W-1:0];

  logic              v1_q, v2_q, v3_q;
  logic [M_W-1:0]    mag, m1_q, m2_q;
  logic [P1_W-1:0]   p1_q;
  logic [M_W-1:0]    qe, qe2_q, q_d, q3_q;
  logic [P2_W-1:0]   p2_q;
  logic [D_W-1:0]    rem;
  logic [SIDE_W-1:0] s1_q, s2_q, s3_q;

  // a non-positive magnitude maps to zero
  assign mag = mag_i[W-1] ? '0 : mag_i[M_W-1:0];
  // estimate is the true quotient or one below it
  assign qe  = M_W'(p1_q >> M_W);
  assign rem = D_W'({m2_q, {c2s_pkg::GAIN_FRAC{1'b0}}}) - D_W'(p2_q);
  assign q_d = (rem >= D_W'(GAIN_K)) ? qe2_q + 1'b1 : qe2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q  <= mag;
      p1_q  <= P1_W'(mag) * P1_W'(RECIP_K);
      s1_q  <= side_i;
      m2_q  <= m1_q;
      qe2_q <= qe;
      p2_q  <= P2_W'(qe) * P2_W'(GAIN_K);
      s2_q  <= s1_q;
      q3_q  <= q_d;
      s3_q  <= s2_q;
    end
  end

  assign valid_o = v3_q;
  assign quot_o  = q3_q;
  assign side_o  = s3_q;

endmodule

@@ src/c2s_skid.sv @@
// Output register with a skid entry; the upstream enable is registered.
// No dependencies.
`timescale 1ns / 1ps

module c2s_skid #(
  parameter int DATA_W = 48
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              ready_o,
  output logic              valid_o,
  output logic [DATA_W-1:0] data_o,
  input  logic              ready_i
);

  logic              out_valid_q, skid_valid_q;
  logic [DATA_W-1:0] out_data_q, skid_data_q;

  assign ready_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      // drain the skid entry once the output moves
      if (ready_i) begin
        skid_valid_q <= 1'b0;
      end
    end else if (valid_i) begin
      if (out_valid_q && !ready_i) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (ready_i) begin
        out_data_q <= skid_data_q;
      end
    end else if (valid_i) begin
      if (out_valid_q && !ready_i) begin
        skid_data_q <= data_i;
      end else begin
        out_data_q <= data_i;
      end
    end
  end

endmodule

@@ src/cartesian_to_spherical.sv @@
// Top level of the cartesian-to-spherical converter: input stage, two CORDIC
// vectoring passes with gain removal, result formatting and output buffer.
// Depends on c2s_pkg, c2s_cordic, c2s_gain and c2s_skid.
`timescale 1ns / 1ps

// Channel   Direction  Payload (tdata, lowest bits first)
// s_axis    in         coord_x, coord_y, coord_z (COORD_WIDTH each, signed)
// m_axis    out        radius (COORD_WIDTH), azimuth, polar (ANGLE_WIDTH each)
//
// One item per cycle while the output is not stalled. Input accept to output valid passes
// the input stage, two unrolled CORDIC passes (one stage per iteration) each followed by
// the three-stage gain removal, the second pass setup, the result and output registers.
// Reset clears all valid bits; payload registers are not reset.
// A stalled output holds in the output register; one more item lands in a skid
// entry, then the whole pipeline freezes in place until the skid drains.

module cartesian_to_spherical #(
  parameter int COORD_WIDTH   = 16,
  parameter int ANGLE_WIDTH   = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // coord_x, coord_y, coord_z, zero pad to whole bytes
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  // radius, azimuth, polar, zero pad to whole bytes
  output logic [((COORD_WIDTH+2*ANGLE_WIDTH+7)/8)*8-1:0] m_axis_tdata_o
);

  localparam int CW      = COORD_WIDTH;
  localparam int AW      = ANGLE_WIDTH;
  localparam int FG      = c2s_pkg::FRAC_GUARD;
  localparam int TW      = c2s_pkg::TURN_W;
  localparam int W       = CW + FG + 3;        // signed CORDIC datapath width
  localparam int M_W     = W - 1;              // unsigned magnitude width
  localparam int OUT_W   = ((CW + 2*AW + 7) / 8) * 8;
  localparam int SIDE1_W = 1 + CW;             // on-axis flag, y
  localparam int SIDE2_W = SIDE1_W + TW;       // plus azimuth angle
  localparam int SIDE3_W = SIDE2_W + TW;       // plus polar angle
  localparam logic [TW:0]   HALF_LSB = (33'd1 << (TW - AW)) >> 1;
  localparam logic [M_W:0]  RAD_HALF = (M_W+1)'(1) << (FG - 1);
  localparam logic [M_W:0]  RAD_MAX  = (M_W+1)'({CW{1'b1}});

  // round to the output angle width, modulo a full turn
  function automatic logic [AW-1:0] round_turn(input logic [TW-1:0] ang);
    logic [TW:0] sum;
    sum = {1'b0, ang} + HALF_LSB;
    return sum[TW-1:TW-AW];
  endfunction

  logic en;

  // ---------------- input stage: half-turn fold for z < 0 ----------------
  logic signed [CW-1:0]   in_x, in_y, in_z;
  logic signed [W-1:0]    x_ext, z_ext;
  logic                   s0_valid_q;
  logic signed [W-1:0]    s0_a_q, s0_b_q;
  logic [TW-1:0]          s0_ang_q;
  logic [SIDE1_W-1:0]     s0_side_q;

  assign in_x  = s_axis_tdata_i[CW-1:0];
  assign in_y  = s_axis_tdata_i[2*CW-1:CW];
  assign in_z  = s_axis_tdata_i[3*CW-1:2*CW];
  assign x_ext = {{(W-CW){in_x[CW-1]}}, in_x} <<< FG;
  assign z_ext = {{(W-CW){in_z[CW-1]}}, in_z} <<< FG;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (en) begin
      s0_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_a_q    <= in_z[CW-1] ? -z_ext : z_ext;
      s0_b_q    <= in_z[CW-1] ? -x_ext : x_ext;
      s0_ang_q  <= in_z[CW-1] ? c2s_pkg::HALF_TURN : '0;
      s0_side_q <= {(in_x == '0) && (in_z == '0), in_y};
    end
  end

  // ---------------- first pass on (z, x): azimuth and xz length ----------------
  logic                c1_valid;
  logic signed [W-1:0] c1_a;
  logic [TW-1:0]       c1_ang;
  logic [SIDE1_W-1:0]  c1_side;

  c2s_cordic #(.W(W), .STAGES(CORDIC_STAGES), .SIDE_W(SIDE1_W)) u_cordic_az (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(s0_valid_q), .a_i(s0_a_q), .b_i(s0_b_q), .ang_i(s0_ang_q), .side_i(s0_side_q),
    .valid_o(c1_valid), .a_o(c1_a), .ang_o(c1_ang), .side_o(c1_side)
  );

  logic               g1_valid;
  logic [M_W-1:0]     g1_mag;
  logic [SIDE2_W-1:0] g1_side;

  c2s_gain #(.W(W), .STAGES(CORDIC_STAGES), .SIDE_W(SIDE2_W)) u_gain_az (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(c1_valid), .mag_i(c1_a), .side_i({c1_side, c1_ang}),
    .valid_o(g1_valid), .quot_o(g1_mag), .side_o(g1_side)
  );

  // ---------------- second pass setup: fold for y < 0 ----------------
  logic signed [CW-1:0] g1_y;
  logic signed [W-1:0]  y_ext, rxz;
  logic                 s2_valid_q;
  logic signed [W-1:0]  s2_a_q, s2_b_q;
  logic [TW-1:0]        s2_ang_q;
  logic [SIDE2_W-1:0]   s2_side_q;

  assign g1_y  = g1_side[TW+CW-1:TW];
  assign y_ext = {{(W-CW){g1_y[CW-1]}}, g1_y} <<< FG;
  assign rxz   = {1'b0, g1_mag};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= g1_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_a_q    <= g1_y[CW-1] ? -y_ext : y_ext;
      s2_b_q    <= g1_y[CW-1] ? -rxz : rxz;
      s2_ang_q  <= g1_y[CW-1] ? c2s_pkg::HALF_TURN : '0;
      s2_side_q <= g1_side;
    end
  end

  // ---------------- second pass on (y, rxz): polar angle and radius ----------------
  logic                c2_valid;
  logic signed [W-1:0] c2_a;
  logic [TW-1:0]       c2_ang;
  logic [SIDE2_W-1:0]  c2_side;

  c2s_cordic #(.W(W), .STAGES(CORDIC_STAGES), .SIDE_W(SIDE2_W)) u_cordic_pol (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(s2_valid_q), .a_i(s2_a_q), .b_i(s2_b_q), .ang_i(s2_ang_q), .side_i(s2_side_q),
    .valid_o(c2_valid), .a_o(c2_a), .ang_o(c2_ang), .side_o(c2_side)
  );

  logic               g2_valid;
  logic [M_W-1:0]     g2_mag;
  logic [SIDE3_W-1:0] g2_side;

  c2s_gain #(.W(W), .STAGES(CORDIC_STAGES), .SIDE_W(SIDE3_W)) u_gain_pol (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(c2_valid), .mag_i(c2_a), .side_i({c2_side, c2_ang}),
    .valid_o(g2_valid), .quot_o(g2_mag), .side_o(g2_side)
  );

  // ---------------- result formatting ----------------
  logic                 on_axis;
  logic signed [CW-1:0] g2_y;
  logic [TW-1:0]        ang_az, ang_pol, pol_clamp;
  logic [M_W:0]         rad_sum, rad_full;
  logic [CW-1:0]        rad, y_abs;
  logic [CW-1:0]        res_rad;
  logic [AW-1:0]        res_az, res_pol;
  logic                 res_valid_q;
  logic [OUT_W-1:0]     res_data_q;

  assign ang_pol = g2_side[TW-1:0];
  assign ang_az  = g2_side[2*TW-1:TW];
  assign g2_y    = g2_side[2*TW+CW-1:2*TW];
  assign on_axis = g2_side[SIDE3_W-1];

  always_comb begin
    // drop guard bits with round-half-up, saturate
    rad_sum  = {1'b0, g2_mag} + RAD_HALF;
    rad_full = rad_sum >> FG;
    rad      = (rad_full > RAD_MAX) ? {CW{1'b1}} : rad_full[CW-1:0];
    y_abs    = g2_y[CW-1] ? CW'(-g2_y) : CW'(g2_y);

    // clamp polar residue: last quarter turn reads 0, above a half turn reads pi
    if (ang_pol >= c2s_pkg::THREE_QUARTER) begin
      pol_clamp = '0;
    end else if (ang_pol > c2s_pkg::HALF_TURN) begin
      pol_clamp = c2s_pkg::HALF_TURN;
    end else begin
      pol_clamp = ang_pol;
    end

    // vector on the y axis (or zero): exact answers
    if (on_axis) begin
      res_rad = y_abs;
      res_az  = '0;
      res_pol = g2_y[CW-1] ? round_turn(c2s_pkg::HALF_TURN) : '0;
    end else begin
      res_rad = rad;
      res_az  = round_turn(ang_az);
      res_pol = round_turn(pol_clamp);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (en) begin
      res_valid_q <= g2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_data_q <= OUT_W'({res_pol, res_az, res_rad});
    end
  end

  // ---------------- output buffer; its ready freezes the whole pipeline ----------------
  c2s_skid #(.DATA_W(OUT_W)) u_skid (
    .clk_i, .rst_ni,
    .valid_i(res_valid_q), .data_i(res_data_q), .ready_o(en),
    .valid_o(m_axis_tvalid_o), .data_o(m_axis_tdata_o), .ready_i(m_axis_tready_i)
  );

  assign s_axis_tready_o = en;

endmodule
